// ===== rtl/core/receive_admission_dedup_filter_core_assert.svh =====
`ifndef RECEIVE_ADMISSION_DEDUP_FILTER_CORE_ASSERT_SVH
`define RECEIVE_ADMISSION_DEDUP_FILTER_CORE_ASSERT_SVH

// same-cycle implication check
`define RDF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdf check failed");

// next-cycle implication check
`define RDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdf check failed");

`endif

// ===== rtl/core/rdf_pkg.sv =====
package rdf_pkg;

   localparam int CacheEntries = 16;
   localparam int QueueDepth   = 16;

   localparam int MacW   = 48;
   localparam int SeqW   = 16;
   localparam int AckW   = 2;
   localparam int CountW = 5;

   localparam int CacheIdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
   localparam int CacheCntW = $clog2(CacheEntries + 1);
   localparam int OccW      = $clog2(QueueDepth + 1);

   localparam logic [AckW-1:0] AckOk       = 2'd0;
   localparam logic [AckW-1:0] AckWrongDst = 2'd1;
   localparam logic [AckW-1:0] AckFull     = 2'd2;

   localparam logic CmdAdmit = 1'b0;
   localparam logic CmdPop   = 1'b1;

   typedef struct packed {
      logic            start;
      logic            wr_en;
      logic [MacW-1:0] src;
      logic [SeqW-1:0] seq;
   } cache_req_type;

   typedef struct packed {
      logic done;
      logic hit;
   } cache_sts_type;

endpackage

// ===== rtl/core/rdf_cache.sv =====
`include "receive_admission_dedup_filter_core_assert.svh"

module rdf_cache (
   input  logic                   clock,
   input  logic                   reset,
   input  rdf_pkg::cache_req_type cache_req,
   output rdf_pkg::cache_sts_type cache_sts
);
   import rdf_pkg::*;

   logic [MacW-1:0]         src_mem [CacheEntries];
   logic [SeqW-1:0]         seq_mem [CacheEntries];
   logic [CacheEntries-1:0] valid_ff;
   logic [CacheIdxW-1:0]    ptr_ff;
   logic                    busy_ff;
   logic [CacheCntW-1:0]    cnt_ff;
   logic [MacW-1:0]         rd_src_ff;
   logic [SeqW-1:0]         rd_seq_ff;
   logic                    rdv_ff;
   logic                    hit_ff;

   logic                    scan_rd;
   logic [CacheIdxW-1:0]    rd_idx;
   logic                    match;
   logic                    done;

   assign scan_rd = busy_ff && (cnt_ff < CacheCntW'(CacheEntries));
   assign rd_idx  = cnt_ff[CacheIdxW-1:0];
   assign match   = rdv_ff && (rd_src_ff == cache_req.src) && (rd_seq_ff == cache_req.seq);
   assign done    = busy_ff && (cnt_ff == CacheCntW'(CacheEntries));

   assign cache_sts.done = done;
   assign cache_sts.hit  = hit_ff | match;

   // pair storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cache_req.wr_en) begin
         src_mem[ptr_ff] <= cache_req.src;
         seq_mem[ptr_ff] <= cache_req.seq;
      end
      if (scan_rd) begin
         rd_src_ff <= src_mem[rd_idx];
         rd_seq_ff <= seq_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         rdv_ff   <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         if (cache_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rdv_ff  <= 1'b0;
            hit_ff  <= 1'b0;
         end else if (busy_ff) begin
            rdv_ff <= scan_rd && valid_ff[rd_idx];
            hit_ff <= hit_ff | match;
            if (scan_rd) begin
               cnt_ff <= cnt_ff + CacheCntW'(1);
            end
            if (done) begin
               busy_ff <= 1'b0;
            end
         end
         if (cache_req.wr_en) begin
            valid_ff[ptr_ff] <= 1'b1;
            if (ptr_ff == CacheIdxW'(CacheEntries - 1)) begin
               ptr_ff <= '0;
            end else begin
               ptr_ff <= ptr_ff + CacheIdxW'(1);
            end
         end
      end
   end

   `RDF_ASSERT_SAME(a_start_when_idle, clock, reset, cache_req.start, !busy_ff)
   `RDF_ASSERT_SAME(a_write_at_scan_end, clock, reset, cache_req.wr_en, done)
   `RDF_ASSERT_NEXT(a_start_begins_scan, clock, reset, cache_req.start, busy_ff && cnt_ff == '0)
   `RDF_ASSERT_NEXT(a_done_ends_scan, clock, reset, done, !busy_ff)

endmodule

// ===== rtl/core/receive_admission_dedup_filter_core.sv =====
// pop and wrong-destination items: result valid in the cycle after the input transfer
// admitted frames: one cache entry read and compared per cycle, result valid after all
// CacheEntries entries have been read and compared
// one item at a time: no new request is taken until the response to the last one is accepted
// synchronous reset clears the cache valid marks, replace pointer, queue count and local_mac
`include "receive_admission_dedup_filter_core_assert.svh"

module receive_admission_dedup_filter_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rdf_pkg::MacW-1:0]     csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_cmd,
   input  logic [rdf_pkg::MacW-1:0]     req_dst_mac,
   input  logic [rdf_pkg::MacW-1:0]     req_src_mac,
   input  logic [rdf_pkg::SeqW-1:0]     req_seq,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rdf_pkg::AckW-1:0]     rsp_ack_code,
   output logic                         rsp_enqueued,
   output logic                         rsp_duplicate,
   output logic                         rsp_pop_valid,
   output logic [rdf_pkg::CountW-1:0]   rsp_queue_count
);
   import rdf_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [MacW-1:0] local_mac_ff;
   logic [OccW-1:0] occ_ff, occ_in;
   logic [MacW-1:0] src_ff;
   logic [SeqW-1:0] seq_ff;
   logic [AckW-1:0] ack_ff, ack_in;
   logic            enq_ff, enq_in;
   logic            dup_ff, dup_in;
   logic            popv_ff, popv_in;

   logic            req_xfer;
   cache_req_type   cache_req;
   cache_sts_type   cache_sts;

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == S_IDLE);
   assign req_xfer        = req_valid && req_ready;
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_ack_code    = ack_ff;
   assign rsp_enqueued    = enq_ff;
   assign rsp_duplicate   = dup_ff;
   assign rsp_pop_valid   = popv_ff;
   assign rsp_queue_count = CountW'(occ_ff);

   rdf_cache u_cache (
      .clock     (clock),
      .reset     (reset),
      .cache_req (cache_req),
      .cache_sts (cache_sts)
   );

   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      ack_in          = ack_ff;
      enq_in          = enq_ff;
      dup_in          = dup_ff;
      popv_in         = popv_ff;
      cache_req.start = 1'b0;
      cache_req.wr_en = 1'b0;
      cache_req.src   = src_ff;
      cache_req.seq   = seq_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               ack_in  = AckOk;
               enq_in  = 1'b0;
               dup_in  = 1'b0;
               popv_in = 1'b0;
               if (req_cmd == CmdPop) begin
                  if (occ_ff != '0) begin
                     occ_in  = occ_ff - OccW'(1);
                     popv_in = 1'b1;
                  end
                  state_in = S_RESP;
               end else if (req_dst_mac != local_mac_ff) begin
                  ack_in   = AckWrongDst;
                  state_in = S_RESP;
               end else begin
                  cache_req.start = 1'b1;
                  state_in        = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cache_sts.done) begin
               if (cache_sts.hit) begin
                  dup_in = 1'b1;
               end else if (occ_ff >= OccW'(QueueDepth)) begin
                  ack_in = AckFull;
               end else begin
                  occ_in          = occ_ff + OccW'(1);
                  enq_in          = 1'b1;
                  cache_req.wr_en = 1'b1;
               end
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         local_mac_ff <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (csr_valid && csr_ready) begin
            local_mac_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ack_ff  <= ack_in;
      enq_ff  <= enq_in;
      dup_ff  <= dup_in;
      popv_ff <= popv_in;
      if (req_xfer) begin
         src_ff <= req_src_mac;
         seq_ff <= req_seq;
      end
   end

   `RDF_ASSERT_SAME(a_occ_bound, clock, reset, 1'b1, occ_ff <= OccW'(QueueDepth))
   `RDF_ASSERT_NEXT(a_done_gives_rsp, clock, reset, cache_sts.done, rsp_valid)
   `RDF_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_xfer, !req_ready)

endmodule
